FILE: rtl/llsl_pkg.sv
// Shared constants for the linear lag slew unit.
package llsl_pkg;

  localparam int unsigned SAMPLE_BITS_DEF = 24;
  localparam int unsigned FRAC_BITS_DEF   = 24;
  localparam int unsigned RAMP_BITS       = 16;
  localparam logic [RAMP_BITS-1:0] RAMP_RESET = 16'd480;

endpackage

FILE: rtl/llsl_div.sv
// Restoring divider: one quotient bit per cycle, unsigned dividend by unsigned divisor.
module llsl_div #(
  parameter int unsigned DW = 48,
  parameter int unsigned VW = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quot_o
);

  localparam int unsigned CW = $clog2(DW);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [VW-1:0] rem_q;
  logic [DW-1:0] quot_q;
  logic [VW-1:0] div_q;

  logic [VW:0]   trial;
  logic [VW:0]   diff;
  logic          ge;

  assign trial = {rem_q, quot_q[DW-1]};
  assign diff  = trial - {1'b0, div_q};
  assign ge    = (trial >= {1'b0, div_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CW'(DW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // quot_q starts as the dividend; quotient bits shift in from the bottom
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      quot_q <= dividend_i;
      div_q  <= divisor_i;
    end else if (busy_q) begin
      rem_q  <= ge ? diff[VW-1:0] : trial[VW-1:0];
      quot_q <= {quot_q[DW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

FILE: rtl/linear_lag_slew_unit.sv
// Top level: linear-ramp slew limiter for one audio channel.
//
//  channel   dir  handshake              payload
//  s_axis    in   s_axis_tvalid/tready   tdata: sample_in (signed Q1.23)
//  m_axis    out  m_axis_tvalid/tready   tdata: sample_out (signed Q1.23)
//  cfg       in   cfg_we                 wdata: ramp_samples
//
// While ramping, each item runs the shared restoring divider up to twice.
// Reset clears control state at once, not sob_q or out_q; there is no clearing pass.
// A finished sample sits in the output register; the next request is taken meanwhile
// and its result waits until the output is free.
module linear_lag_slew_unit #(
  parameter int unsigned SAMPLE_BITS = llsl_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned FRAC_BITS   = llsl_pkg::FRAC_BITS_DEF,
  localparam int unsigned TDATA_W    = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [llsl_pkg::RAMP_BITS-1:0] cfg_wdata_i,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [TDATA_W-1:0]             s_axis_tdata_i,  // [SAMPLE_BITS-1:0] sample_in
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [TDATA_W-1:0]             m_axis_tdata_o   // [SAMPLE_BITS-1:0] sample_out
);

  import llsl_pkg::*;

  localparam int unsigned LW = SAMPLE_BITS + FRAC_BITS;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHK   = 3'd1;
  localparam logic [2:0] ST_WAIT1 = 3'd2;
  localparam logic [2:0] ST_APPLY = 3'd3;
  localparam logic [2:0] ST_SET2  = 3'd4;
  localparam logic [2:0] ST_WAIT2 = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  logic [2:0]             state_q, state_d;
  logic [RAMP_BITS-1:0]   ramp_q;
  logic [SAMPLE_BITS-1:0] sob_q;     // input in offset binary
  logic [SAMPLE_BITS-1:0] target_q;
  logic [LW-1:0]          level_q;
  logic [RAMP_BITS-1:0]   rem_q;
  logic [LW-1:0]          slope_q;
  logic                   neg_q;
  logic [SAMPLE_BITS-1:0] out_q;
  logic                   mvalid_q;

  logic                   in_fire;
  logic                   out_free;
  logic                   changed;
  logic [LW-1:0]          goal;
  logic                   dist_neg;
  logic [LW-1:0]          dist_mag;
  logic                   div_start;
  logic [RAMP_BITS-1:0]   div_divisor;
  logic                   div_done;
  logic [LW-1:0]          div_quot;

  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !mvalid_q || m_axis_tready_i;
  assign changed  = (sob_q != target_q);

  // after the change check target equals sob_q, so sob_q serves as the goal throughout
  assign goal     = {sob_q, {FRAC_BITS{1'b0}}};
  assign dist_neg = (level_q > goal);
  assign dist_mag = dist_neg ? (level_q - goal) : (goal - level_q);

  assign div_start = ((state_q == ST_CHK) && changed && (ramp_q != '0)) ||
                     ((state_q == ST_SET2) && (rem_q != '0));
  assign div_divisor = (state_q == ST_CHK) ? ramp_q : rem_q;

  llsl_div #(
    .DW (LW),
    .VW (RAMP_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dist_mag),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_fire) state_d = ST_CHK;
      ST_CHK:   state_d = div_start ? ST_WAIT1 : ST_APPLY;
      ST_WAIT1: if (div_done) state_d = ST_APPLY;
      ST_APPLY: state_d = (rem_q != '0) ? ST_SET2 : ST_OUT;
      ST_SET2:  state_d = div_start ? ST_WAIT2 : ST_OUT;
      ST_WAIT2: if (div_done) state_d = ST_OUT;
      ST_OUT:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ramp_q <= RAMP_RESET;
    end else if (cfg_we_i) begin
      ramp_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      target_q <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      level_q  <= {1'b1, {(LW-1){1'b0}}};
      rem_q    <= '0;
      slope_q  <= '0;
      neg_q    <= 1'b0;
      mvalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((state_q == ST_OUT) && out_free) begin
        mvalid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        mvalid_q <= 1'b0;
      end
      case (state_q)
        ST_CHK: begin
          if (changed) begin
            target_q <= sob_q;
            rem_q    <= ramp_q;
            if (ramp_q == '0) begin
              slope_q <= '0;
              neg_q   <= 1'b0;
            end else begin
              neg_q   <= dist_neg;
            end
          end
        end
        ST_WAIT1, ST_WAIT2: begin
          if (div_done) slope_q <= div_quot;
        end
        ST_APPLY: begin
          if (rem_q != '0) begin
            rem_q   <= rem_q - 1'b1;
            level_q <= neg_q ? (level_q - slope_q) : (level_q + slope_q);
          end else begin
            level_q <= goal;
          end
        end
        ST_SET2: begin
          if (rem_q == '0) begin
            slope_q <= '0;
            neg_q   <= 1'b0;
          end else begin
            neg_q   <= dist_neg;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sob_q <= {~s_axis_tdata_i[SAMPLE_BITS-1], s_axis_tdata_i[SAMPLE_BITS-2:0]};
    end
    if ((state_q == ST_OUT) && out_free) begin
      out_q <= {~level_q[LW-1], level_q[LW-2 -: SAMPLE_BITS-1]};
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = mvalid_q;
  assign m_axis_tdata_o  = TDATA_W'(out_q);

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_WAIT1 || state_q == ST_WAIT2))
    else $error("divider finished outside a wait state");

  a_accept_to_chk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == ST_CHK))
    else $error("accepted sample did not enter the change check");

  a_ramp_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && rem_q == '0) |-> (level_q == {target_q, {FRAC_BITS{1'b0}}}))
    else $error("level off target with no ramp running");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && !out_free) |=> (state_q == ST_OUT && mvalid_q))
    else $error("result dropped while output busy");

endmodule

FILE: verif/linear_lag_slew_unit_tb.sv
// Testbench for the linear lag slew unit: self-checking ramp predictor with random stalls.
`timescale 1ns / 100ps

module linear_lag_slew_unit_tb;

  localparam int unsigned SW = llsl_pkg::SAMPLE_BITS_DEF;
  localparam int unsigned FW = llsl_pkg::FRAC_BITS_DEF;
  localparam int unsigned LW = SW + FW;
  localparam int unsigned RW = llsl_pkg::RAMP_BITS;
  localparam int unsigned TDATA_W = ((SW + 7) / 8) * 8;

  localparam logic [SW-1:0] SIGN_FLIP  = SW'(1) << (SW - 1);
  localparam logic [SW-1:0] SMP_MAX    = SIGN_FLIP - 1'b1;
  localparam logic [SW-1:0] SMP_MIN    = SIGN_FLIP;
  localparam logic [SW-1:0] SMP_ZERO   = '0;
  localparam logic [SW-1:0] SMP_NEG1   = '1;
  localparam logic [RW-1:0] RAMP_MAX   = '1;
  localparam int            SETTLE_CYC = 120;
  localparam longint        CYCLE_LIMIT = 1_000_000;
  localparam int            PHASE_ITEMS = 85;
  localparam int            ERR_PRINT_MAX = 20;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [RW-1:0]      cfg_wdata_i = '0;
  logic               s_axis_tvalid_i = 1'b0;
  logic               s_axis_tready_o;
  logic [TDATA_W-1:0] s_axis_tdata_i = '0;  // [SW-1:0] sample_in
  logic               m_axis_tvalid_o;
  logic               m_axis_tready_i = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata_o;       // [SW-1:0] sample_out

  linear_lag_slew_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #5 clk_i = ~clk_i;

  // Slew predictor state (offset-binary level and target, sign/magnitude slope)
  logic [LW-1:0] lvl;
  logic [SW-1:0] tgt;
  logic [RW-1:0] steps_left;
  logic [LW-1:0] slope_mag;
  logic          slope_down;
  logic [RW-1:0] ramp_len;

  logic [SW-1:0] expected_samples[$];

  int     fails;
  int     mismatch_prints;
  int     requests_sent;
  int     samples_checked;
  int     ramp_steps;
  int     ramp_restarts;
  int     ramp_writes;
  longint cycles;
  bit     steady_mode;
  int     rx_hold;
  logic [SW-1:0] last_level_sent;

  function automatic void reset_predictor();
    lvl        = {SIGN_FLIP, {FW{1'b0}}};
    tgt        = SIGN_FLIP;
    steps_left = '0;
    slope_mag  = '0;
    slope_down = 1'b0;
    ramp_len   = llsl_pkg::RAMP_RESET;
  endfunction

  // slope = remaining distance / remaining steps, truncated toward zero
  function automatic void retune_slope();
    logic [LW-1:0] goal;
    goal = {tgt, {FW{1'b0}}};
    if (steps_left == 0) begin
      slope_mag  = '0;
      slope_down = 1'b0;
    end else if (goal >= lvl) begin
      slope_mag  = (goal - lvl) / steps_left;
      slope_down = 1'b0;
    end else begin
      slope_mag  = (lvl - goal) / steps_left;
      slope_down = 1'b1;
    end
  endfunction

  function automatic logic [SW-1:0] slewed_sample(input logic [SW-1:0] smp);
    logic [SW-1:0] sob;
    sob = smp ^ SIGN_FLIP;
    if (sob != tgt) begin
      if (steps_left != 0) ramp_restarts++;
      tgt        = sob;
      steps_left = ramp_len;
      retune_slope();
    end
    if (steps_left != 0) begin
      ramp_steps++;
      steps_left = steps_left - 1'b1;
      lvl = slope_down ? lvl - slope_mag : lvl + slope_mag;
      retune_slope();
      return lvl[LW-1:FW] ^ SIGN_FLIP;
    end
    lvl = {sob, {FW{1'b0}}};
    return smp;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 80);
  endfunction

  // Sender: tvalid stays high between back-to-back requests
  task automatic send_sample(input logic [SW-1:0] smp);
    int gap;
    gap = (steady_mode || $urandom_range(99) < 60) ? 0 : gap_len();
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid_i <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= TDATA_W'(smp);
    do @(posedge clk_i); while (!s_axis_tready_o);
    expected_samples.push_back(slewed_sample(smp));
    requests_sent++;
    last_level_sent = smp;
  endtask

  task automatic hold_level(input logic [SW-1:0] smp, input int count);
    repeat (count) send_sample(smp);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // Only written once the unit is idle
  task automatic set_ramp(input logic [RW-1:0] len);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    ramp_len = len;
    ramp_writes++;
  endtask

  // Result checker
  always @(posedge clk_i) begin : chk
    logic [SW-1:0] want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_samples.size() == 0) begin
        fails++;
        if (mismatch_prints < ERR_PRINT_MAX)
          $error("sample_out: no request pending, actual %0d",
                 $signed(m_axis_tdata_o[SW-1:0]));
        mismatch_prints++;
      end else begin
        want = expected_samples.pop_front();
        samples_checked++;
        if (m_axis_tdata_o[SW-1:0] !== want) begin
          fails++;
          if (mismatch_prints < ERR_PRINT_MAX)
            $error("sample_out: expected %0d, actual %0d", $signed(want),
                   $signed(m_axis_tdata_o[SW-1:0]));
          mismatch_prints++;
        end
      end
    end
  end

  // Receiver backpressure
  always @(negedge clk_i) begin
    if (rx_hold == 0 && !steady_mode && $urandom_range(99) < 15) rx_hold = gap_len();
    if (rx_hold != 0) begin
      rx_hold--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Reset ramp length of 480 still in force
  task automatic test_reset_state();
    send_sample(SMP_ZERO);
    send_sample(SW'(1));
    send_sample(SMP_MIN);
    send_sample(SMP_MAX);
  endtask

  // Zero ramp length passes input straight through
  task automatic test_pass_through();
    set_ramp('0);
    send_sample(SMP_MAX);
    send_sample(SMP_MIN);
    send_sample(SMP_NEG1);
    send_sample(SW'(24'h5a5a5a));
  endtask

  task automatic test_one_step_ramp();
    set_ramp(RW'(1));
    send_sample(SMP_MAX);
    send_sample(SMP_MIN);
    send_sample(SMP_ZERO);
    send_sample(SMP_ZERO);
  endtask

  // Ramp runs to its end, then a change arrives mid-ramp
  task automatic test_ramp_to_end();
    set_ramp(RW'(3));
    hold_level(SMP_MAX, 5);
    hold_level(SMP_MIN, 2);
    hold_level(SMP_NEG1, 4);
  endtask

  function automatic logic [SW-1:0] pick_level();
    int r;
    r = $urandom_range(99);
    if (r < 20) begin
      case ($urandom_range(3))
        0:       return SMP_MAX;
        1:       return SMP_MIN;
        2:       return SMP_ZERO;
        default: return SMP_NEG1;
      endcase
    end
    if (r < 35) return last_level_sent + SW'($signed($urandom_range(16)) - 8);
    return SW'($urandom);
  endfunction

  task automatic test_random_ramps();
    logic [RW-1:0] len;
    logic [SW-1:0] smp;
    int n;
    int hold;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: len = RAMP_MAX;
        1: len = '0;
        2: len = RW'(1);
        3: len = RW'(2);
        4: len = RW'($urandom_range(3, 12));
        5: len = RW'($urandom_range(13, 64));
        6: len = llsl_pkg::RAMP_RESET;
        default: len = RW'($urandom);
      endcase
      set_ramp(len);
      steady_mode = (phase == 2 || phase == 5);
      n = 0;
      while (n < PHASE_ITEMS) begin
        if ($urandom_range(99) < 15) begin
          send_sample(SW'($urandom));
          n++;
        end else begin
          smp  = pick_level();
          hold = (len < 36) ? $urandom_range(1, len + 4) : $urandom_range(1, 24);
          hold_level(smp, hold);
          n += hold;
        end
      end
      steady_mode = 1'b0;
    end
  endtask

  initial begin
    fails = 0;
    mismatch_prints = 0;
    requests_sent = 0;
    samples_checked = 0;
    ramp_steps = 0;
    ramp_restarts = 0;
    ramp_writes = 0;
    cycles = 0;
    steady_mode = 1'b0;
    rx_hold = 0;
    last_level_sent = '0;
    reset_predictor();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_pass_through();
    test_one_step_ramp();
    test_ramp_to_end();
    test_random_ramps();

    drain_results();
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (expected_samples.size() != 0) fails++;

    $display("Run: %0d requests, %0d samples checked, %0d ramp lengths written (0 to %0d)",
             requests_sent, samples_checked, ramp_writes, RAMP_MAX);
    $display("     %0d ramp steps taken, %0d ramps restarted mid-way, %0d mismatches",
             ramp_steps, ramp_restarts, fails);
    if (fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/llsl_pkg.sv
rtl/llsl_div.sv
rtl/linear_lag_slew_unit.sv
verif/linear_lag_slew_unit_tb.sv
